/* design/tlks_pkg.sv */
// Shared constants, register indexes and the pattern mapping of the keystream core.
package tlks_pkg;

  // Default number of cells in each shift register.
  localparam int unsigned LfsrLengthDef = 16;
  // Width of the seed key and of each tap mask.
  localparam int unsigned KeyBits       = 48;
  localparam int unsigned TapWidth      = 16;
  localparam int unsigned TruthWidth    = 8;
  localparam int unsigned CfgDataWidth  = KeyBits;
  localparam int unsigned CfgIdxWidth   = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_SEED_KEY    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_FIRST_TAPS  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SECOND_TAPS = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_THIRD_TAPS  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_TRUTH_TABLE = 3'd4;

  // Reset values of the tap masks.
  localparam logic [TapWidth-1:0] FirstTapsRst  = 16'hC900;
  localparam logic [TapWidth-1:0] SecondTapsRst = 16'hC110;
  localparam logic [TapWidth-1:0] ThirdTapsRst  = 16'hB400;

  // Maps the emitted bits {b1, b2, b3} onto the truth table bit position.
  function automatic logic [2:0] pattern_of(input logic [2:0] bits);
    logic [2:0] p;
    case (bits)
      3'b000:  p = 3'd0;
      3'b001:  p = 3'd5;
      3'b010:  p = 3'd4;
      3'b011:  p = 3'd6;
      3'b100:  p = 3'd1;
      3'b101:  p = 3'd7;
      3'b110:  p = 3'd2;
      default: p = 3'd3;
    endcase
    return p;
  endfunction

endpackage

/* design/tlks_lfsr.sv */
// One Fibonacci shift register with seed load, tap mask feedback and top cell output.
module tlks_lfsr import tlks_pkg::*; #(
  parameter int unsigned LfsrLength = LfsrLengthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  load_i,
  input  logic [LfsrLength-1:0] seed_i,
  input  logic [TapWidth-1:0]   taps_i,
  output logic                  top_o
);

  logic [LfsrLength-1:0] state_q, state_d;
  logic [LfsrLength-1:0] cur;
  logic [LfsrLength-1:0] mask;
  logic                  fb;

  // Tap bits beyond the register are dropped; cells beyond the mask are never tapped.
  for (genvar i = 0; i < LfsrLength; i++) begin : g_mask
    if (i < TapWidth) begin : g_tap
      assign mask[i] = taps_i[i];
    end else begin : g_none
      assign mask[i] = 1'b0;
    end
  end

  assign cur     = load_i ? seed_i : state_q;
  assign top_o   = cur[LfsrLength-1];
  assign fb      = ^(cur & mask);
  assign state_d = {cur[LfsrLength-2:0], fb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  // An all-zero register that is not reloaded stays all zero.
  a_zero_stays_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !load_i && state_q == '0) |=> (state_q == '0))
    else $error("all-zero register left zero without a reload");

endmodule

/* design/three_lfsr_combination_keystream_core.sv */
// Top level of the three-register combination keystream generator.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  input    | in        | in_valid_i / in_stall_o | restart_i
//  output   | out       | out_valid_o/ out_stall_i| keystream_bit_o, first_out_o, second_out_o,
//           |           |                         | third_out_o
//  config   | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One item is taken in every clock cycle while in_stall_o is low; its result passes from the input
// register to the result register through the single step of the three shift registers.
// Reset clears the shift registers to zero, the tap masks to their defaults and both
// pipeline valid flags; no clearing pass is needed.
// While the output is stalled with a result waiting, the result register holds, the input register
// holds its item, and the input side is stalled only once both registers are full.
module three_lfsr_combination_keystream_core import tlks_pkg::*; #(
  parameter int unsigned LfsrLength = LfsrLengthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    restart_i,
  // Output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    keystream_bit_o,
  output logic                    first_out_o,
  output logic                    second_out_o,
  output logic                    third_out_o
);

  // Configuration registers.
  logic [KeyBits-1:0]    seed_key_q;
  logic [TapWidth-1:0]   first_taps_q, second_taps_q, third_taps_q;
  logic [TruthWidth-1:0] truth_table_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_key_q    <= '0;
      first_taps_q  <= FirstTapsRst;
      second_taps_q <= SecondTapsRst;
      third_taps_q  <= ThirdTapsRst;
      truth_table_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED_KEY:    seed_key_q    <= cfg_wdata_i[KeyBits-1:0];
        CFG_FIRST_TAPS:  first_taps_q  <= cfg_wdata_i[TapWidth-1:0];
        CFG_SECOND_TAPS: second_taps_q <= cfg_wdata_i[TapWidth-1:0];
        CFG_THIRD_TAPS:  third_taps_q  <= cfg_wdata_i[TapWidth-1:0];
        CFG_TRUTH_TABLE: truth_table_q <= cfg_wdata_i[TruthWidth-1:0];
        default: ; // Writes to indexes beyond the register list are ignored.
      endcase
    end
  end

  // Pipeline control. The input register advances whenever the result register is empty
  // or its result is being taken in the same cycle.
  logic s1_valid_q;
  logic restart_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      restart_q <= restart_i;
    end
  end

  // Seed slices: bit j of the key seeds register j div LfsrLength, cell j mod LfsrLength.
  // Cells that fall beyond the key are seeded with zero.
  logic [LfsrLength-1:0] seed_slice [3];
  logic [TapWidth-1:0]   taps       [3];
  logic [2:0]            tops;

  assign taps[0] = first_taps_q;
  assign taps[1] = second_taps_q;
  assign taps[2] = third_taps_q;

  for (genvar r = 0; r < 3; r++) begin : g_reg
    for (genvar c = 0; c < LfsrLength; c++) begin : g_cell
      if (r * LfsrLength + c < KeyBits) begin : g_key
        assign seed_slice[r][c] = seed_key_q[r * LfsrLength + c];
      end else begin : g_zero
        assign seed_slice[r][c] = 1'b0;
      end
    end

    tlks_lfsr #(
      .LfsrLength(LfsrLength)
    ) u_lfsr (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .step_i(s1_adv),
      .load_i(restart_q),
      .seed_i(seed_slice[r]),
      .taps_i(taps[r]),
      .top_o (tops[r])
    );
  end

  // The three emitted bits select one truth table bit through the fixed pattern order.
  logic [2:0] emitted;
  logic       keystream_d;

  assign emitted     = {tops[0], tops[1], tops[2]};
  assign keystream_d = truth_table_q[pattern_of(emitted)];

  logic keystream_q, first_q, second_q, third_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      keystream_q <= keystream_d;
      first_q     <= tops[0];
      second_q    <= tops[1];
      third_q     <= tops[2];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign keystream_bit_o = keystream_q;
  assign first_out_o     = first_q;
  assign second_out_o    = second_q;
  assign third_out_o     = third_q;

  // A held result must never be overwritten by the next step.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !s1_adv)
    else $error("result register overwritten while stalled");

  // An input transfer into a full input register needs that register to move on.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s1_valid_q) |-> s1_adv)
    else $error("input item accepted into an occupied input register");

  // Every step produces a result in the next cycle.
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("step without a result");

endmodule
